// ===== hw/rtl/far_pkg.sv =====
package far_pkg;

    // Largest pattern and replacement this block handles.
    localparam int MAX_PAT_BYTES = 8;
    localparam int MAX_REP_BYTES = 8;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LEN = 2'd3;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] len_t;
    typedef logic [4:0] cnt_t;

    // One command from the matcher to the emitter.
    typedef struct packed {
        byte_t chr;        // input byte of this transaction
        len_t  old_len;    // held prefix length before this byte
        len_t  seq_cnt;    // bytes of (held prefix, chr) sent on unchanged
        logic  rep;        // a full match completed: send the replacement
        len_t  flush_cnt;  // held prefix bytes flushed at end of string
        logic  str_end;    // this command closes the string
    } far_cmd_t;

    // Byte k of a 64-bit word, first byte in bits 7:0.
    function automatic byte_t byte_sel(logic [63:0] word, logic [2:0] k);
        return word[{k, 3'b000} +: 8];
    endfunction

endpackage

// ===== hw/rtl/far_ifs.sv =====
// Input channel: one string byte and its end mark per transaction.
interface far_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_byte_valid;
    logic       in_end;

    modport source (output valid, in_byte, in_byte_valid, in_end, input ready);
    modport sink (input valid, in_byte, in_byte_valid, in_end, output ready);
endinterface

// Output channel: one result byte and its end mark per transaction.
interface far_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_byte_valid;
    logic       out_end;

    modport source (output valid, out_byte, out_byte_valid, out_end, input ready);
    modport sink (input valid, out_byte, out_byte_valid, out_end, output ready);
endinterface

// ===== hw/rtl/far_front.sv =====
module far_front (
    input  logic              clk,
    input  logic              rst_n,
    far_in_if.sink            item,
    input  logic [63:0]       pattern,
    input  far_pkg::len_t     plen,
    input  logic              pat_wr,
    output far_pkg::far_cmd_t cmd,
    output logic              cmd_valid,
    input  logic              cmd_ready
);
    import far_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_WALK = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0] state_reg, state_next;
    len_t       ml_reg, ml_next;
    len_t       m_reg, m_next;
    len_t       old_reg, old_next;
    byte_t      chr_reg, chr_next;
    logic       end_reg, end_next;
    far_cmd_t   cmd_reg, cmd_next;

    logic [2:0] fb_reg [0:MAX_PAT_BYTES-1];
    logic       bld_reg;
    len_t       bi_reg;
    len_t       bk_reg;

    logic [2:0] fb_addr;
    logic [2:0] fb_rd;
    logic       acc;
    len_t       start_ml;
    logic       hit;
    logic       step_back;
    len_t       m_fin;
    logic       matched;
    len_t       new_ml;
    len_t       seq;
    logic       beq;
    len_t       bk_inc;
    logic       bld_done;

    // The failure table has one read port, shared by the builder and the matcher.
    assign fb_addr = bld_reg ? (bk_reg[2:0] - 3'd1) : (m_reg[2:0] - 3'd1);
    assign fb_rd   = fb_reg[fb_addr];

    assign item.ready = (state_reg == F_IDLE) && !bld_reg;
    assign acc        = item.valid && item.ready;
    assign start_ml   = (ml_reg >= plen) ? 4'd0 : ml_reg;

    // One fallback step per cycle while the pattern byte differs from the input.
    assign hit       = byte_sel(pattern, m_reg[2:0]) == chr_reg;
    assign step_back = (m_reg != 4'd0) && !hit;
    assign m_fin     = m_reg + {3'b000, hit};
    assign matched   = m_fin >= plen;
    assign new_ml    = matched ? 4'd0 : m_fin;
    assign seq       = old_reg + 4'd1 - m_fin;

    // Table builder compares pattern byte i with pattern byte k.
    assign beq      = byte_sel(pattern, bi_reg[2:0]) == byte_sel(pattern, bk_reg[2:0]);
    assign bk_inc   = bk_reg + {3'b000, beq};
    assign bld_done = bi_reg >= plen;

    // Matcher sequencer.
    always_comb
    begin
        state_next = state_reg;
        ml_next    = ml_reg;
        m_next     = m_reg;
        old_next   = old_reg;
        chr_next   = chr_reg;
        end_next   = end_reg;
        cmd_next   = cmd_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (acc)
                begin
                    chr_next = item.in_byte;
                    end_next = item.in_end;
                    old_next = start_ml;
                    m_next   = start_ml;
                    if (item.in_byte_valid)
                    begin
                        state_next = F_WALK;
                    end
                    else if (item.in_end)
                    begin
                        cmd_next = '{chr: 8'd0, old_len: 4'd0, seq_cnt: 4'd0, rep: 1'b0,
                                     flush_cnt: start_ml, str_end: 1'b1};
                        ml_next    = 4'd0;
                        state_next = F_PUSH;
                    end
                end
            end
            F_WALK:
            begin
                if (step_back)
                begin
                    m_next = {1'b0, fb_rd};
                end
                else
                begin
                    cmd_next = '{chr: chr_reg, old_len: old_reg, seq_cnt: seq, rep: matched,
                                 flush_cnt: end_reg ? new_ml : 4'd0, str_end: end_reg};
                    ml_next    = end_reg ? 4'd0 : new_ml;
                    state_next = ((seq != 4'd0) || matched || end_reg) ? F_PUSH : F_IDLE;
                end
            end
            F_PUSH:
            begin
                if (cmd_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
        // A new pattern drops any held prefix.
        if (pat_wr)
        begin
            ml_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            ml_reg    <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            ml_reg    <= ml_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        old_reg <= old_next;
        chr_reg <= chr_next;
        end_reg <= end_next;
        cmd_reg <= cmd_next;
    end

    // Failure table builder: restarts on every pattern or length write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bld_reg <= 1'b0;
            bi_reg  <= 4'd0;
            bk_reg  <= 4'd0;
            for (int i = 0; i < MAX_PAT_BYTES; i++)
            begin
                fb_reg[i] <= 3'd0;
            end
        end
        else if (pat_wr)
        begin
            bld_reg <= 1'b1;
            bi_reg  <= 4'd1;
            bk_reg  <= 4'd0;
            for (int i = 0; i < MAX_PAT_BYTES; i++)
            begin
                fb_reg[i] <= 3'd0;
            end
        end
        else if (bld_reg)
        begin
            if (bld_done)
            begin
                bld_reg <= 1'b0;
            end
            else if ((bk_reg != 4'd0) && !beq)
            begin
                bk_reg <= {1'b0, fb_rd};
            end
            else
            begin
                fb_reg[bi_reg[2:0]] <= bk_inc[2:0];
                bk_reg              <= bk_inc;
                bi_reg              <= bi_reg + 4'd1;
            end
        end
    end

    assign cmd_valid = (state_reg == F_PUSH);
    assign cmd       = cmd_reg;

endmodule

// ===== hw/rtl/far_queue.sv =====
module far_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  far_pkg::far_cmd_t push_cmd,
    input  logic              push_valid,
    output logic              push_ready,
    output far_pkg::far_cmd_t pop_cmd,
    output logic              pop_valid,
    input  logic              pop_ready
);
    import far_pkg::*;

    far_cmd_t   slot_reg [0:1];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_cmd    = slot_reg[rp_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Occupancy count.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= !rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/far_back.sv =====
module far_back (
    input  logic              clk,
    input  logic              rst_n,
    input  far_pkg::far_cmd_t cmd,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  logic [63:0]       pattern,
    input  logic [63:0]       replace,
    input  far_pkg::len_t     rlen,
    far_out_if.source         result
);
    import far_pkg::*;

    logic     busy_reg;
    far_cmd_t cur_reg;
    cnt_t     j_reg;
    cnt_t     last_reg;
    logic     bare_reg;
    len_t     rep_n_reg;
    logic     out_valid_reg;
    byte_t    out_byte_reg;
    logic     out_bval_reg;
    logic     out_end_reg;

    len_t     rep_n;
    cnt_t     tot;
    logic     pop;
    logic     adv;
    cnt_t     jr;
    cnt_t     jf;
    byte_t    seq_byte;
    byte_t    cur_byte;

    // Total results of the next command.
    assign rep_n = cmd.rep ? rlen : 4'd0;
    assign tot   = cnt_t'(cmd.seq_cnt) + cnt_t'(rep_n) + cnt_t'(cmd.flush_cnt);

    assign cmd_ready = !busy_reg;
    assign pop       = cmd_valid && cmd_ready;
    assign adv       = busy_reg && (!out_valid_reg || result.ready);

    // Byte j runs over the sent-on bytes, the replacement, then the flushed prefix.
    assign jr       = j_reg - cnt_t'(cur_reg.seq_cnt);
    assign jf       = jr - cnt_t'(rep_n_reg);
    assign seq_byte = (j_reg < cnt_t'(cur_reg.old_len)) ? byte_sel(pattern, j_reg[2:0])
                                                        : cur_reg.chr;

    always_comb
    begin
        if (j_reg < cnt_t'(cur_reg.seq_cnt))
        begin
            cur_byte = seq_byte;
        end
        else if (jr < cnt_t'(rep_n_reg))
        begin
            cur_byte = byte_sel(replace, jr[2:0]);
        end
        else
        begin
            cur_byte = byte_sel(pattern, jf[2:0]);
        end
    end

    // Command expansion: one result per cycle while the output register is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (pop)
        begin
            busy_reg <= (tot != 5'd0) || cmd.str_end;
        end
        else if (adv && (j_reg == last_reg))
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg   <= cmd;
            rep_n_reg <= rep_n;
            j_reg     <= 5'd0;
            bare_reg  <= (tot == 5'd0);
            last_reg  <= (tot == 5'd0) ? 5'd0 : (tot - 5'd1);
        end
        else if (adv)
        begin
            j_reg <= j_reg + 5'd1;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_byte_reg <= bare_reg ? 8'd0 : cur_byte;
            out_bval_reg <= !bare_reg;
            out_end_reg  <= cur_reg.str_end && (j_reg == last_reg);
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.out_byte       = out_byte_reg;
    assign result.out_byte_valid = out_bval_reg;
    assign result.out_end        = out_end_reg;

endmodule

// ===== hw/rtl/find_and_replace_all_top.sv =====
// The matcher takes a new input byte only once it is done with the last, and the emitter
// gives one result per cycle while the output is not stalled, taking a new command only
// after the last result of the one before.
// A pattern or length write rebuilds the failure table and holds off input while it runs.
// Reset (rst_n low, asynchronous) empties the queue, clears the partial match and the table,
// and loads pattern 0 of length 1 and an empty replacement.
module find_and_replace_all_top (
    input  logic                             clk,
    input  logic                             rst_n,
    far_in_if.sink                           item,
    far_out_if.source                        result,
    input  logic                             cfg_we,
    input  logic [far_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [far_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import far_pkg::*;

    logic [63:0] pat_reg;
    len_t        plen_reg;
    logic [63:0] rep_reg;
    len_t        rlen_reg;

    len_t        plen_eff;
    len_t        rlen_eff;
    logic        pat_wr;

    far_cmd_t    f_cmd;
    logic        f_valid;
    logic        f_ready;
    far_cmd_t    b_cmd;
    logic        b_valid;
    logic        b_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg  <= 64'd0;
            plen_reg <= 4'd1;
            rep_reg  <= 64'd0;
            rlen_reg <= 4'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN:     pat_reg  <= cfg_wdata;
                CFG_PATTERN_LEN: plen_reg <= cfg_wdata[3:0];
                CFG_REPLACE:     rep_reg  <= cfg_wdata;
                CFG_REPLACE_LEN: rlen_reg <= cfg_wdata[3:0];
                default:         pat_reg  <= pat_reg;
            endcase
        end
    end

    // Effective lengths: a zero pattern length counts as one, both saturate.
    assign plen_eff = (plen_reg == 4'd0) ? 4'd1 :
                      (plen_reg > len_t'(MAX_PAT_BYTES)) ? len_t'(MAX_PAT_BYTES) : plen_reg;
    assign rlen_eff = (rlen_reg > len_t'(MAX_REP_BYTES)) ? len_t'(MAX_REP_BYTES) : rlen_reg;
    assign pat_wr   = cfg_we && ((cfg_index == CFG_PATTERN) || (cfg_index == CFG_PATTERN_LEN));

    far_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .pattern   (pat_reg),
        .plen      (plen_eff),
        .pat_wr    (pat_wr),
        .cmd       (f_cmd),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready)
    );

    far_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (f_cmd),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .pop_cmd    (b_cmd),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready)
    );

    far_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (b_cmd),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .pattern   (pat_reg),
        .replace   (rep_reg),
        .rlen      (rlen_eff),
        .result    (result)
    );

endmodule

// ===== hw/rtl/far_chk.sv =====
module far_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           item_valid,
    input logic                           item_ready,
    input logic                           item_byte_valid,
    input logic                           result_valid,
    input logic                           result_ready,
    input logic [7:0]                     result_byte,
    input logic                           result_byte_valid,
    input logic                           result_end,
    input logic                           cfg_we,
    input logic [far_pkg::CFG_IDX_W-1:0]  cfg_index
);
    import far_pkg::*;

    // A stalled result transaction holds its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_byte)
        && $stable(result_byte_valid) && $stable(result_end))
    else $error("result payload changed while stalled");

    // A result without a byte is only a bare end mark with a zero byte.
    a_bare_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_byte_valid |-> result_end && (result_byte == 8'd0))
    else $error("byteless result is not a bare end mark");

    // A new pattern holds off input while the failure table is rebuilt.
    a_rebuild_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && ((cfg_index == CFG_PATTERN) || (cfg_index == CFG_PATTERN_LEN))
        |=> !item_ready)
    else $error("input accepted during failure table rebuild");

    // A byte transaction keeps the matcher busy for at least the next cycle.
    a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_byte_valid |=> !item_ready)
    else $error("input accepted while matcher busy");

endmodule

bind find_and_replace_all_top far_chk u_far_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .item_byte_valid   (item.in_byte_valid),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_byte       (result.out_byte),
    .result_byte_valid (result.out_byte_valid),
    .result_end        (result.out_end),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index)
);
